// ===== src/cde_pkg.sv =====
// Shared types, codes and calendar helpers for the calendar date engine.
// Depends on nothing; every other file imports it.
package cde_pkg;

  localparam logic [11:0] FIRST_YEAR = 12'd1901;
  localparam logic [11:0] LAST_YEAR  = 12'd2099;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } cde_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_SUM,
    ST_FIN
  } cde_state_t;

  typedef struct packed {
    logic        action;
    logic [11:0] given_year;
    logic [3:0]  given_month;
    logic [4:0]  given_day;
    logic [15:0] days_to_advance;
  } cde_req_t;

  typedef struct packed {
    logic [11:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [2:0]  weekday;
    logic [1:0]  status;
    logic        is_before;
    logic        is_same;
  } cde_rsp_t;

  function automatic logic [4:0] days_in(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:    len = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] cum;
    case (m)
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

  function automatic logic date_ok(input logic [11:0] y, input logic [3:0] m,
                                   input logic [4:0] d);
    return (y >= FIRST_YEAR) && (y <= LAST_YEAR) && (d != 5'd0) && (d <= days_in(y, m));
  endfunction

  // fold base-8 digits, since 8 is 1 mod 7
  function automatic logic [2:0] mod7(input logic [9:0] x);
    logic [4:0] s1;
    logic [3:0] s2;
    s1 = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

// ===== src/cde_if.sv =====
// Request and result channel interfaces for the calendar date engine.
// Depends on cde_pkg for the payload structs.
interface cde_req_if import cde_pkg::*; ();
  logic     valid;
  logic     ready;
  cde_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cde_rsp_if import cde_pkg::*; ();
  logic     valid;
  logic     ready;
  cde_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/calendar_date_engine.sv =====
// Calendar date engine: stored date, month-walking advance, weekday and compare.
// Depends on cde_pkg and the channel interfaces in cde_if.sv.
//
// Usage: one request on req gives exactly one result on rsp.
// A load request sets the date if it is valid (else status 1, date kept).
// An advance request moves the date forward by days_to_advance, one month
// per cycle through a single subtract-and-compare unit; a date past
// 2099-12-31 gives status 2 and keeps the old date.
// For the largest days_to_advance, an advance walks at most about 2160 months.
// req.ready is high only while the sequencer is idle. A finished result sits
// in an output register; while rsp is stalled a new request is still taken
// and walked, and only its final write-out waits for the register to empty.
// Reset (rst, synchronous) sets the date to 1901-01-01 and empties the
// output register.
module calendar_date_engine import cde_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cde_req_if.sink   req,
  cde_rsp_if.source rsp
);

  cde_state_t  state, state_next;

  logic [11:0] sy;
  logic [3:0]  sm;
  logic [4:0]  sd;

  logic [11:0] wy;
  logic [3:0]  wm;
  logic [16:0] remaining_days;

  logic [11:0] gy;
  logic [3:0]  gm;
  logic [4:0]  gd;
  cde_status_t status;
  logic [9:0]  day_sum;

  logic        rsp_valid;
  cde_rsp_t    rsp_data;

  logic        accept;
  logic        emit;
  logic [4:0]  dim;
  logic        step_more;
  logic        over;
  logic        load_ok;
  logic [7:0]  year_off;
  logic        precedes;
  logic        same;

  assign accept    = req.valid && req.ready;
  assign dim       = days_in(wy, wm);
  assign step_more = remaining_days > 17'(dim);
  assign over      = step_more && (wm == MONTH_DEC) && (wy == LAST_YEAR);
  assign load_ok   = date_ok(req.data.given_year, req.data.given_month, req.data.given_day);
  assign year_off  = 8'(sy - FIRST_YEAR);
  assign emit      = (state == ST_FIN) && (!rsp_valid || rsp.ready);
  assign precedes  = (sy < gy) || ((sy == gy) && ((sm < gm) || ((sm == gm) && (sd < gd))));
  assign same      = (sy == gy) && (sm == gm) && (sd == gd);

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (req.data.action == ACT_ADVANCE) ? ST_WALK : ST_SUM;
        end
      end
      ST_WALK: begin
        if (!step_more || over) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: state_next = ST_FIN;
      ST_FIN: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // stored date and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      sy        <= FIRST_YEAR;
      sm        <= MONTH_JAN;
      sd        <= 5'd1;
      rsp_valid <= 1'b0;
    end else begin
      if (accept && req.data.action == ACT_LOAD && load_ok) begin
        sy <= req.data.given_year;
        sm <= req.data.given_month;
        sd <= req.data.given_day;
      end else if (state == ST_WALK && !step_more) begin
        sy <= wy;
        sm <= wm;
        sd <= remaining_days[4:0];
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // walk registers, request capture and result formation
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          gy <= req.data.given_year;
          gm <= req.data.given_month;
          gd <= req.data.given_day;
          wy <= sy;
          wm <= sm;
          remaining_days <= 17'(sd) + 17'(req.data.days_to_advance);
          if (req.data.action == ACT_LOAD && !load_ok) begin
            status <= STATUS_BAD_DATE;
          end else begin
            status <= STATUS_OK;
          end
        end
      end
      ST_WALK: begin
        if (over) begin
          status <= STATUS_OVERFLOW;
        end else if (step_more) begin
          remaining_days <= remaining_days - 17'(dim);
          if (wm == MONTH_DEC) begin
            wm <= MONTH_JAN;
            wy <= wy + 12'd1;
          end else begin
            wm <= wm + 4'd1;
          end
        end
      end
      ST_SUM: begin
        day_sum <= 10'd1 + 10'(year_off) + 10'(year_off[7:2]) + 10'(days_before_month(sm))
                 + 10'((sm > MONTH_FEB) && (sy[1:0] == 2'b00)) + 10'(sd);
      end
      ST_FIN: begin
        if (emit) begin
          rsp_data.cur_year  <= sy;
          rsp_data.cur_month <= sm;
          rsp_data.cur_day   <= sd;
          rsp_data.weekday   <= mod7(day_sum);
          rsp_data.status    <= status;
          rsp_data.is_before <= precedes;
          rsp_data.is_same   <= same;
        end
      end
      default: ;
    endcase
  end

  a_stored_valid: assert property (@(posedge clk) disable iff (rst)
    (sy >= FIRST_YEAR) && (sy <= LAST_YEAR) && (sd != 5'd0) && (sd <= days_in(sy, sm)))
    else $error("stored date out of range");

  a_walk_month: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (wm >= MONTH_JAN) && (wm <= MONTH_DEC))
    else $error("walk month out of range");

  a_date_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM || state == ST_FIN) |=> $stable(sy) && $stable(sm) && $stable(sd))
    else $error("stored date changed after the walk");

  a_emit_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside the final state");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_data.weekday <= 3'd6)
    else $error("weekday out of range");

endmodule
